// ===== hw/rtl/ntab_pkg.sv =====
// Shared widths, result codes and register indexes of the neighbor table.
`default_nettype none
package ntab_pkg;

	localparam int ID_W      = 64;
	localparam int WORD_W    = 32;
	localparam int TIMEOUT_W = 16;
	localparam int OUTCOME_W = 3;
	localparam int SLOT_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	localparam logic [OUTCOME_W-1:0] OUT_REFRESHED = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_OWN       = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_TICK      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

endpackage
`default_nettype wire

// ===== hw/rtl/ntab_if.sv =====
// Request and response channels of the neighbor table.
`default_nettype none
interface ntab_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [ntab_pkg::ID_W-1:0]  vehicle_id_high;
	logic [ntab_pkg::ID_W-1:0]  vehicle_id_low;
	logic [ntab_pkg::WORD_W-1:0] latitude_bits;
	logic [ntab_pkg::WORD_W-1:0] longitude_bits;
	logic [ntab_pkg::WORD_W-1:0] speed_bits;
	logic [ntab_pkg::WORD_W-1:0] now_ms;

	modport source (output valid, req_type, vehicle_id_high, vehicle_id_low, latitude_bits,
		longitude_bits, speed_bits, now_ms, input ready);
	modport sink (input valid, req_type, vehicle_id_high, vehicle_id_low, latitude_bits,
		longitude_bits, speed_bits, now_ms, output ready);
endinterface

interface ntab_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ntab_pkg::OUTCOME_W-1:0]  outcome;
	logic [ntab_pkg::SLOT_W-1:0]     slot;
	logic [ntab_pkg::COUNT_W-1:0]    entry_count;
	logic [ntab_pkg::COUNT_W-1:0]    removed_count;

	modport source (output valid, outcome, slot, entry_count, removed_count, input ready);
	modport sink (input valid, outcome, slot, entry_count, removed_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/neighbor_table_with_aging.sv =====
// Neighbor table with timeout aging: sequencer, table memory and result register.
// An own-id report skips the walk and goes straight to the final state; other reports
// and ticks walk the table through its single read port, one entry per cycle. A report
// stops at its matching entry; otherwise all entries held are read before the final state.
// Throughput: one item at a time; the next transfer is taken once the result is loaded.
// Reset clears entry count, handshake and config (timeout 5000); table contents are not cleared.
`default_nettype none
module neighbor_table_with_aging #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ntab_req_if.sink                                req,
	ntab_rsp_if.source                              rsp,
	input  wire logic                               cfg_we,
	input  wire logic [ntab_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [ntab_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [ntab_pkg::ID_W-1:0]   id_high;
		logic [ntab_pkg::ID_W-1:0]   id_low;
		logic [ntab_pkg::WORD_W-1:0] latitude;
		logic [ntab_pkg::WORD_W-1:0] longitude;
		logic [ntab_pkg::WORD_W-1:0] speed;
		logic [ntab_pkg::WORD_W-1:0] seen_ms;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [ntab_pkg::ID_W-1:0]      own_high_q;
	logic [ntab_pkg::ID_W-1:0]      own_low_q;
	logic [ntab_pkg::TIMEOUT_W-1:0] timeout_q;

	// table
	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_q;
	logic [CNT_W-1:0] count_q;

	// current item and walk
	entry_t     item_q;
	logic       tick_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic       cmp_v_s1;
	logic [CNT_W-1:0] cmp_idx_s1;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] removed_q;
	logic [ntab_pkg::OUTCOME_W-1:0] res_outcome_q;
	logic [IDX_W-1:0] res_slot_q;

	// output register
	logic                              rsp_valid_q;
	logic [ntab_pkg::OUTCOME_W-1:0]    rsp_outcome_q;
	logic [ntab_pkg::SLOT_W-1:0]       rsp_slot_q;
	logic [ntab_pkg::COUNT_W-1:0]      rsp_count_q;
	logic [ntab_pkg::COUNT_W-1:0]      rsp_removed_q;

	logic       accept;
	logic       own_match;
	logic       scan;
	logic       issue;
	logic       id_eq;
	logic       stale;
	logic       hit;
	logic       drop;
	logic       keep;
	logic       done;
	logic       room;
	logic [ntab_pkg::WORD_W-1:0] age;
	logic       mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t     mem_wdata;
	entry_t     req_entry;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign req_entry = '{id_high: req.vehicle_id_high, id_low: req.vehicle_id_low,
		latitude: req.latitude_bits, longitude: req.longitude_bits,
		speed: req.speed_bits, seen_ms: req.now_ms};

	assign own_match = (req.vehicle_id_high == own_high_q) && (req.vehicle_id_low == own_low_q);

	always_comb begin
		scan  = (state_q == ST_SCAN);
		issue = scan && (rd_idx_q < count_q);
		id_eq = (rd_data_q.id_high == item_q.id_high) && (rd_data_q.id_low == item_q.id_low);
		age   = item_q.seen_ms - rd_data_q.seen_ms;
		stale = age > ntab_pkg::WORD_W'(timeout_q);
		hit   = scan && cmp_v_s1 && !tick_q && id_eq;
		drop  = scan && cmp_v_s1 && tick_q && stale;
		keep  = scan && cmp_v_s1 && tick_q && !stale;
		done  = scan && !cmp_v_s1 && (rd_idx_q == count_q);
		room  = count_q < CNT_W'(TABLE_DEPTH);

		mem_we    = 1'b0;
		mem_waddr = cmp_idx_s1[IDX_W-1:0];
		mem_wdata = item_q;
		if (hit) begin
			mem_we = 1'b1;
		end else if (keep && (kept_q != cmp_idx_s1)) begin
			// close the gap left by removed entries
			mem_we    = 1'b1;
			mem_waddr = kept_q[IDX_W-1:0];
			mem_wdata = rd_data_q;
		end else if (done && !tick_q && room) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_high_q <= '0;
			own_low_q  <= '0;
			timeout_q  <= ntab_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				ntab_pkg::CFG_OWN_ID_HIGH: own_high_q <= cfg_data;
				ntab_pkg::CFG_OWN_ID_LOW:  own_low_q  <= cfg_data;
				ntab_pkg::CFG_TIMEOUT:     timeout_q  <= cfg_data[ntab_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			cmp_v_s1      <= 1'b0;
			rd_idx_q      <= '0;
			rsp_valid_q   <= 1'b0;
			tick_q        <= 1'b0;
			kept_q        <= '0;
			removed_q     <= '0;
			res_outcome_q <= ntab_pkg::OUT_TICK;
			res_slot_q    <= '0;
		end else begin
			// the final state loads the result register itself
			if (rsp.ready && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q     <= req_entry;
						tick_q     <= req.req_type;
						rd_idx_q   <= '0;
						cmp_v_s1   <= 1'b0;
						kept_q     <= '0;
						removed_q  <= '0;
						res_slot_q <= '0;
						if (!req.req_type && own_match) begin
							res_outcome_q <= ntab_pkg::OUT_OWN;
							state_q       <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_v_s1   <= issue;
					cmp_idx_s1 <= rd_idx_q;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (drop) begin
						removed_q <= removed_q + 1'b1;
					end
					if (keep) begin
						kept_q <= kept_q + 1'b1;
					end
					if (hit) begin
						res_outcome_q <= ntab_pkg::OUT_REFRESHED;
						res_slot_q    <= cmp_idx_s1[IDX_W-1:0];
						state_q       <= ST_FIN;
					end else if (done) begin
						state_q <= ST_FIN;
						if (tick_q) begin
							res_outcome_q <= ntab_pkg::OUT_TICK;
							count_q       <= kept_q;
						end else if (room) begin
							res_outcome_q <= ntab_pkg::OUT_INSERTED;
							res_slot_q    <= count_q[IDX_W-1:0];
							count_q       <= count_q + 1'b1;
						end else begin
							res_outcome_q <= ntab_pkg::OUT_FULL;
						end
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_outcome_q <= res_outcome_q;
						rsp_slot_q    <= ntab_pkg::SLOT_W'(res_slot_q);
						rsp_count_q   <= ntab_pkg::COUNT_W'(count_q);
						rsp_removed_q <= ntab_pkg::COUNT_W'(removed_q);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.outcome       = rsp_outcome_q;
	assign rsp.slot          = rsp_slot_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.removed_count = rsp_removed_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ntab_checker.sv =====
// Port-level checks of the neighbor table, bound to the top level.
`default_nettype none
module ntab_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_ready,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [ntab_pkg::OUTCOME_W-1:0]    outcome,
	input wire logic [ntab_pkg::SLOT_W-1:0]       slot,
	input wire logic [ntab_pkg::COUNT_W-1:0]      entry_count,
	input wire logic [ntab_pkg::COUNT_W-1:0]      removed_count
);

	// a stalled result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(slot)
			&& $stable(entry_count) && $stable(removed_count))
		else $error("result changed while stalled");

	// one item at a time: ready drops after each transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// only refresh and insert name a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (outcome == ntab_pkg::OUT_FULL || outcome == ntab_pkg::OUT_OWN
			|| outcome == ntab_pkg::OUT_TICK) |-> slot == '0)
		else $error("slot set on a result without one");

	// reports never remove entries
	a_report_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (outcome == ntab_pkg::OUT_REFRESHED || outcome == ntab_pkg::OUT_INSERTED
			|| outcome == ntab_pkg::OUT_FULL || outcome == ntab_pkg::OUT_OWN)
			|-> removed_count == '0)
		else $error("report shows removed entries");

endmodule

bind neighbor_table_with_aging ntab_checker u_ntab_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.outcome       (rsp.outcome),
	.slot          (rsp.slot),
	.entry_count   (rsp.entry_count),
	.removed_count (rsp.removed_count)
);
`default_nettype wire

// ===== bench/tb_neighbor_table_with_aging.sv =====
// Self-checking testbench for the neighbor table: directed and random reports and ticks.
`timescale 1ns / 100ps
module tb_neighbor_table_with_aging;

	localparam int DEPTH = 16;
	localparam int POOL = 24;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 280;
	localparam logic REQ_REPORT = 1'b0;
	localparam logic REQ_TICK = 1'b1;
	localparam logic [ntab_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic req_type;
		logic [ntab_pkg::ID_W-1:0] id_hi;
		logic [ntab_pkg::ID_W-1:0] id_lo;
		logic [ntab_pkg::WORD_W-1:0] lat;
		logic [ntab_pkg::WORD_W-1:0] lon;
		logic [ntab_pkg::WORD_W-1:0] spd;
		logic [ntab_pkg::WORD_W-1:0] now;
	} neighbor_msg_t;

	typedef struct {
		logic [ntab_pkg::OUTCOME_W-1:0] outcome;
		logic [ntab_pkg::SLOT_W-1:0] slot;
		logic [ntab_pkg::COUNT_W-1:0] entry_count;
		logic [ntab_pkg::COUNT_W-1:0] removed_count;
	} table_reply_t;

	// Mirror of the neighbor table plus the replies it should produce.
	class neighbor_scoreboard;
		logic [ntab_pkg::ID_W-1:0] own_hi;
		logic [ntab_pkg::ID_W-1:0] own_lo;
		logic [ntab_pkg::TIMEOUT_W-1:0] timeout;
		logic [ntab_pkg::ID_W-1:0] tab_hi[DEPTH];
		logic [ntab_pkg::ID_W-1:0] tab_lo[DEPTH];
		logic [ntab_pkg::WORD_W-1:0] tab_lat[DEPTH];
		logic [ntab_pkg::WORD_W-1:0] tab_lon[DEPTH];
		logic [ntab_pkg::WORD_W-1:0] tab_spd[DEPTH];
		logic [ntab_pkg::WORD_W-1:0] tab_seen[DEPTH];
		int unsigned live;
		table_reply_t awaited[$];
		int unsigned errors;

		function new();
			own_hi = '0;
			own_lo = '0;
			timeout = ntab_pkg::TIMEOUT_RESET;
			live = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [ntab_pkg::CFG_IDX_W-1:0] idx,
				logic [ntab_pkg::CFG_DAT_W-1:0] data);
			case (idx)
				ntab_pkg::CFG_OWN_ID_HIGH: own_hi = data;
				ntab_pkg::CFG_OWN_ID_LOW: own_lo = data;
				ntab_pkg::CFG_TIMEOUT: timeout = data[ntab_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		endfunction

		function void store_payload(int k, neighbor_msg_t m);
			tab_lat[k] = m.lat;
			tab_lon[k] = m.lon;
			tab_spd[k] = m.spd;
			tab_seen[k] = m.now;
		endfunction

		function void note_request(neighbor_msg_t m);
			table_reply_t r;
			int unsigned kept;
			int unsigned dropped;
			logic [ntab_pkg::WORD_W-1:0] age;
			int hit;
			r.outcome = ntab_pkg::OUT_TICK;
			r.slot = '0;
			r.removed_count = '0;
			if (m.req_type == REQ_TICK) begin
				kept = 0;
				dropped = 0;
				for (int k = 0; k < live; k++) begin
					age = m.now - tab_seen[k];
					if (age > {16'd0, timeout}) begin
						dropped++;
					end else begin
						tab_hi[kept] = tab_hi[k];
						tab_lo[kept] = tab_lo[k];
						tab_lat[kept] = tab_lat[k];
						tab_lon[kept] = tab_lon[k];
						tab_spd[kept] = tab_spd[k];
						tab_seen[kept] = tab_seen[k];
						kept++;
					end
				end
				live = kept;
				r.removed_count = ntab_pkg::COUNT_W'(dropped);
			end else if (m.id_hi == own_hi && m.id_lo == own_lo) begin
				r.outcome = ntab_pkg::OUT_OWN;
			end else begin
				hit = -1;
				for (int k = 0; k < live; k++)
					if (hit < 0 && tab_hi[k] == m.id_hi && tab_lo[k] == m.id_lo)
						hit = k;
				if (hit >= 0) begin
					store_payload(hit, m);
					r.outcome = ntab_pkg::OUT_REFRESHED;
					r.slot = ntab_pkg::SLOT_W'(hit);
				end else if (live < DEPTH) begin
					tab_hi[live] = m.id_hi;
					tab_lo[live] = m.id_lo;
					store_payload(live, m);
					r.outcome = ntab_pkg::OUT_INSERTED;
					r.slot = ntab_pkg::SLOT_W'(live);
					live++;
				end else begin
					r.outcome = ntab_pkg::OUT_FULL;
				end
			end
			r.entry_count = ntab_pkg::COUNT_W'(live);
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(table_reply_t got);
			table_reply_t want;
			if (awaited.size() == 0) begin
				$display("%0t: reply with none expected, actual outcome %0d slot %0d count %0d removed %0d",
					$time, got.outcome, got.slot, got.entry_count, got.removed_count);
				errors++;
			end else begin
				want = awaited.pop_front();
				compare_field("outcome", want.outcome, got.outcome);
				compare_field("slot", want.slot, got.slot);
				compare_field("entry_count", want.entry_count, got.entry_count);
				compare_field("removed_count", want.removed_count, got.removed_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ntab_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ntab_pkg::CFG_DAT_W-1:0] cfg_data;
	logic [15:0] stall_seed;
	logic [3:0] stall_pos;
	logic steady;
	logic [ntab_pkg::WORD_W-1:0] sim_now;
	logic [127:0] id_pool[POOL];
	int unsigned quiet_cycles;
	neighbor_scoreboard sb;

	ntab_req_if req();
	ntab_rsp_if rsp();

	neighbor_table_with_aging #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls follow a rotating 16-bit pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_pos <= '0;
		end else begin
			rsp.ready <= stall_seed[stall_pos];
			stall_pos <= stall_pos + 4'd1;
		end
	end

	always @(posedge clk) begin : watch_rsp
		table_reply_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.outcome = rsp.outcome;
			got.slot = rsp.slot;
			got.entry_count = rsp.entry_count;
			got.removed_count = rsp.removed_count;
			sb.check_reply(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_neighbor_table_with_aging: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic neighbor_msg_t report_msg(logic [ntab_pkg::ID_W-1:0] hi,
			logic [ntab_pkg::ID_W-1:0] lo, logic [ntab_pkg::WORD_W-1:0] lat,
			logic [ntab_pkg::WORD_W-1:0] lon, logic [ntab_pkg::WORD_W-1:0] spd,
			logic [ntab_pkg::WORD_W-1:0] now);
		neighbor_msg_t m;
		m.req_type = REQ_REPORT;
		m.id_hi = hi;
		m.id_lo = lo;
		m.lat = lat;
		m.lon = lon;
		m.spd = spd;
		m.now = now;
		return m;
	endfunction

	function automatic neighbor_msg_t tick_msg(logic [ntab_pkg::WORD_W-1:0] now);
		neighbor_msg_t m;
		m = report_msg({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
			$urandom, now);
		m.req_type = REQ_TICK;
		return m;
	endfunction

	function automatic neighbor_msg_t draw_request();
		neighbor_msg_t m;
		int unsigned pick;
		int unsigned sub;
		int unsigned k;
		logic [127:0] id;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			sub = $urandom_range(0, 3);
			if (sub == 0 && sb.live > 0) begin
				// land on or just past the timeout boundary of one entry
				k = $urandom_range(0, sb.live - 1);
				sim_now = sb.tab_seen[k] + ntab_pkg::WORD_W'(sb.timeout)
					+ ntab_pkg::WORD_W'($urandom_range(0, 1));
			end else if (sub == 1) begin
				sim_now = sim_now + ntab_pkg::WORD_W'($urandom_range(0, 2 * sb.timeout + 2));
			end else begin
				sim_now = sim_now + ntab_pkg::WORD_W'($urandom_range(0, sb.timeout / 8 + 2));
			end
			m = tick_msg(sim_now);
		end else begin
			if (pick < 18)
				id = {$urandom, $urandom, $urandom, $urandom};
			else if (pick < 21)
				id = {sb.own_hi, sb.own_lo};
			else
				id = id_pool[$urandom_range(0, POOL - 1)];
			if ($urandom_range(0, 29) == 0) begin
				m = report_msg(id[127:64], id[63:0], $urandom, $urandom, $urandom, $urandom);
			end else begin
				sim_now = sim_now + ntab_pkg::WORD_W'($urandom_range(0, sb.timeout / 8 + 2));
				m = report_msg(id[127:64], id[63:0], $urandom, $urandom, $urandom, sim_now);
			end
		end
		return m;
	endfunction

	task automatic push_request(neighbor_msg_t m);
		req.valid <= 1'b1;
		req.req_type <= m.req_type;
		req.vehicle_id_high <= m.id_hi;
		req.vehicle_id_low <= m.id_lo;
		req.latitude_bits <= m.lat;
		req.longitude_bits <= m.lon;
		req.speed_bits <= m.spd;
		req.now_ms <= m.now;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(m);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && sent < count; j++) begin
				push_request(draw_request());
				sent++;
			end
			if (!steady && $urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		req.valid <= 1'b0;
	endtask

	task automatic settle();
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [ntab_pkg::CFG_IDX_W-1:0] idx,
			logic [ntab_pkg::CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic run_phase(logic [ntab_pkg::ID_W-1:0] hi, logic [ntab_pkg::ID_W-1:0] lo,
			logic [ntab_pkg::TIMEOUT_W-1:0] tmo);
		settle();
		write_reg(ntab_pkg::CFG_OWN_ID_HIGH, hi);
		write_reg(ntab_pkg::CFG_OWN_ID_LOW, lo);
		write_reg(ntab_pkg::CFG_TIMEOUT, {48'd0, tmo});
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		stall_seed <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
		steady <= ($urandom_range(0, 3) == 0);
		sim_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 255) : $urandom;
		@(posedge clk);
		run_random(PHASE_ITEMS);
	endtask

	initial begin : stimulus
		int unsigned len;
		logic [127:0] id;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = REQ_REPORT;
		req.vehicle_id_high = '0;
		req.vehicle_id_low = '0;
		req.latitude_bits = '0;
		req.longitude_bits = '0;
		req.speed_bits = '0;
		req.now_ms = '0;
		stall_seed = 16'hFFFF;
		steady = 1'b1;
		sim_now = '0;
		sb = new();

		// a mix of fully random ids and short zero-padded names
		for (int i = 0; i < POOL; i++) begin
			if (i % 3 == 0) begin
				id_pool[i] = {$urandom, $urandom, $urandom, $urandom};
			end else begin
				id = '0;
				len = $urandom_range(1, 15);
				for (int b = 0; b < len; b++)
					id[127 - 8 * b -: 8] = 8'($urandom_range(1, 255));
				id_pool[i] = id;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: own id at reset value, extremes, wrap, full table, boundary ages
		stall_seed <= 16'h5A5B;
		push_request(report_msg('0, '0, 32'h1, 32'h2, 32'h3, 32'h0));
		push_request(report_msg('1, '1, '1, '1, '1, 32'hFFFF_FFF0));
		push_request(report_msg(64'h4100_0000_0000_0000, '0, '0, '0, '0, 32'hFFFF_FFF8));
		push_request(report_msg('1, '1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, '0, 32'h10));
		push_request(tick_msg(32'h20));
		for (int i = 0; i < 14; i++)
			push_request(report_msg(64'(i), ~64'(i), $urandom, $urandom, $urandom,
				32'h100 + i));
		push_request(report_msg(64'hDEAD_BEEF, 64'h1, '0, '0, '0, 32'h300));
		push_request(report_msg(64'd13, ~64'd13, '1, '0, '1, 32'h200));
		push_request(tick_msg(32'hFFFF_FFF8 + 32'd5000));
		push_request(tick_msg(32'hFFFF_FFF8 + 32'd5001));
		push_request(tick_msg(32'hFFFF_FFFF));
		push_request(report_msg('1, '1, '0, '1, '0, 32'h0));
		req.valid <= 1'b0;

		steady <= 1'b0;
		@(posedge clk);
		run_random(PHASE_ITEMS);
		run_phase('1, '1, 16'd0);
		run_phase(id_pool[3][127:64], id_pool[3][63:0], 16'hFFFF);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom_range(1, 2000)));
		run_phase('0, '1, 16'd1);
		run_phase(id_pool[0][127:64], id_pool[0][63:0], ntab_pkg::TIMEOUT_RESET);
		run_phase({$urandom, $urandom}, '0, 16'($urandom));

		settle();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb_neighbor_table_with_aging: clean");
		else
			$display("tb_neighbor_table_with_aging: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ntab_pkg.sv
hw/rtl/ntab_if.sv
hw/rtl/neighbor_table_with_aging.sv
hw/rtl/ntab_checker.sv
bench/tb_neighbor_table_with_aging.sv
